// File: hdl/rcst_pkg.sv
package rcst_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int KEY_BITS    = 16;
  localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int REFS_BITS   = 8;
  localparam logic [REFS_BITS-1:0] REFS_MAX = '1;

  // request codes
  localparam logic [1:0] OP_GET   = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // response status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_LOAD      = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_WRITEBACK = 3'd4;
  localparam logic [2:0] ST_WB_FREE   = 3'd5;
  localparam logic [2:0] ST_ERROR     = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_HIT,
    ACT_CLAIM,
    ACT_PUT,
    ACT_CLEAR
  } act_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                 scan;
    logic                 pick;
    logic                 is_get;
    logic                 is_put;
    act_t                 act;
    logic [KEY_BITS-1:0]  key;
    logic [5:0]           slot;
  } cell_cmd_t;

  // passed from each cell to the next higher one
  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } chain_t;

  // contents of the selected cell, zero from all others
  typedef struct packed {
    logic [SLOT_BITS-1:0] idx;
    logic [REFS_BITS-1:0] refs;
    logic [KEY_BITS-1:0]  key;
  } view_t;

endpackage

// File: hdl/refcounted_inode_slot_table_top.sv
// Channel  Dir  Fields in tdata (low bit first)
// s_*      in   op[1:0] inode_number[17:2] slot[23:18] links_gone[24]
// m_*      out  slot_index[5:0] status[8:6] released_key[24:9]
//
// Each request passes in turn through accept, match scan in every slot cell,
// lowest-index pick along the cell chain, then update and response.
// The response register may still wait on m_tready while the next request
// is accepted; the update step stalls until that register is free.
// rst is synchronous; it empties the table at once.
module refcounted_inode_slot_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // op, inode_number, slot, links_gone
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // slot_index, status, released_key
);
  import rcst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_APPLY
  } state_t;

  state_t               state;
  logic [1:0]           req_op;
  logic [KEY_BITS-1:0]  req_key;
  logic [5:0]           req_slot;
  logic                 req_gone;
  logic                 any_hit;
  logic                 any_free;

  logic [5:0]           out_slot;
  logic [2:0]           out_status;
  logic [15:0]          out_key;

  cell_cmd_t            cmd;
  chain_t               chain [TABLE_SLOTS+1];
  view_t                hit_views [TABLE_SLOTS];
  logic [SLOT_BITS-1:0] free_idxs [TABLE_SLOTS];
  view_t                hit_view;
  logic [SLOT_BITS-1:0] free_idx;
  logic                 out_free;
  act_t                 act;
  logic [5:0]           res_slot;
  logic [2:0]           res_status;
  logic [15:0]          res_key;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {7'b0, out_key, out_status, out_slot};
  assign out_free = !m_tvalid || m_tready;

  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    rcst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .idx       (SLOT_BITS'(i)),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .hit_view  (hit_views[i]),
      .free_idx  (free_idxs[i])
    );
  end

  // at most one cell drives a nonzero view
  always_comb begin
    hit_view = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit_view = hit_view | hit_views[i];
      free_idx = free_idx | free_idxs[i];
    end
  end

  always_comb begin
    act        = ACT_NONE;
    res_slot   = '0;
    res_status = ST_ERROR;
    res_key    = '0;
    case (req_op)
      OP_GET: begin
        if (any_hit) begin
          res_slot = 6'(hit_view.idx);
          if (hit_view.refs == REFS_MAX) begin
            res_status = ST_ERROR;
          end else begin
            res_status = ST_HIT;
            act        = ACT_HIT;
          end
        end else if (any_free) begin
          res_slot   = 6'(free_idx);
          res_status = ST_LOAD;
          act        = ACT_CLAIM;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_PUT: begin
        res_slot = req_slot;
        act      = ACT_PUT;
        if (hit_view.refs == '0) begin
          res_status = ST_ERROR;
        end else if (hit_view.refs == REFS_BITS'(1)) begin
          res_status = req_gone ? ST_WB_FREE : ST_WRITEBACK;
          res_key    = 16'(hit_view.key);
        end else begin
          res_status = ST_DROPPED;
        end
      end
      OP_CLEAR: begin
        res_status = ST_CLEARED;
        act        = ACT_CLEAR;
      end
      default: begin
        res_status = ST_ERROR;
      end
    endcase
  end

  always_comb begin
    cmd.scan   = (state == S_SCAN);
    cmd.pick   = (state == S_PICK);
    cmd.is_get = (req_op == OP_GET);
    cmd.is_put = (req_op == OP_PUT);
    cmd.act    = (state == S_APPLY && out_free) ? act : ACT_NONE;
    cmd.key    = req_key;
    cmd.slot   = req_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      req_op   <= OP_GET;
      any_hit  <= 1'b0;
      any_free <= 1'b0;
    end else begin
      if (state == S_APPLY && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_op   <= s_tdata[1:0];
            req_key  <= KEY_BITS'(s_tdata[17:2]);
            req_slot <= s_tdata[23:18];
            req_gone <= s_tdata[24];
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          any_hit  <= chain[TABLE_SLOTS].hit_seen;
          any_free <= chain[TABLE_SLOTS].free_seen;
          state    <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            out_slot   <= res_slot;
            out_status <= res_status;
            out_key    <= res_key;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/rcst_cell.sv
module rcst_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  rcst_pkg::cell_cmd_t           cmd,
  input  logic [rcst_pkg::SLOT_BITS-1:0] idx,
  input  rcst_pkg::chain_t              chain_in,
  output rcst_pkg::chain_t              chain_out,
  output rcst_pkg::view_t               hit_view,
  output logic [rcst_pkg::SLOT_BITS-1:0] free_idx
);
  import rcst_pkg::*;

  logic [KEY_BITS-1:0]  key;
  logic [REFS_BITS-1:0] refs;
  logic                 match;
  logic                 free;
  logic                 tgt;
  logic                 sel_hit;
  logic                 sel_free;

  // lowest matching / free cell wins: nothing below it has claimed yet
  assign chain_out.hit_seen  = chain_in.hit_seen | match;
  assign chain_out.free_seen = chain_in.free_seen | free;

  always_comb begin
    if (sel_hit || tgt) begin
      hit_view.idx  = idx;
      hit_view.refs = refs;
      hit_view.key  = key;
    end else begin
      hit_view = '0;
    end
    free_idx = sel_free ? idx : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refs     <= '0;
      match    <= 1'b0;
      free     <= 1'b0;
      tgt      <= 1'b0;
      sel_hit  <= 1'b0;
      sel_free <= 1'b0;
    end else begin
      if (cmd.scan) begin
        match    <= cmd.is_get && (refs != '0) && (key == cmd.key);
        free     <= cmd.is_get && (refs == '0);
        tgt      <= cmd.is_put && (32'(idx) == 32'(cmd.slot));
        sel_hit  <= 1'b0;
        sel_free <= 1'b0;
      end
      if (cmd.pick) begin
        sel_hit  <= match & ~chain_in.hit_seen;
        sel_free <= free & ~chain_in.free_seen;
      end
      case (cmd.act)
        ACT_HIT: begin
          if (sel_hit && refs != REFS_MAX) begin
            refs <= refs + REFS_BITS'(1);
          end
        end
        ACT_CLAIM: begin
          if (sel_free) begin
            refs <= REFS_BITS'(1);
          end
        end
        ACT_PUT: begin
          if (tgt && refs != '0) begin
            refs <= refs - REFS_BITS'(1);
          end
        end
        ACT_CLEAR: begin
          refs <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // key is meaningful only while refs is nonzero
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_CLAIM && sel_free) begin
      key <= cmd.key;
    end
  end

endmodule

// File: bench/slot_table_checker.sv
module slot_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // op, inode_number, slot, links_gone
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // slot_index, status, released_key
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcst_pkg::*;

  typedef struct packed {
    logic [5:0]  slot_index;
    logic [2:0]  status;
    logic [15:0] released_key;
  } slot_resp_t;

  logic [KEY_BITS-1:0]  slot_key  [TABLE_SLOTS];
  logic [REFS_BITS-1:0] slot_refs [TABLE_SLOTS];
  slot_resp_t           awaited_resps [$];
  slot_resp_t           want;
  int                   mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic void empty_table();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_key[i]  = '0;
      slot_refs[i] = '0;
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  // Applies one request to the shadow table and returns the response it earns.
  function automatic slot_resp_t serve_request(input logic [31:0] req);
    slot_resp_t          r;
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    logic [5:0]          s;
    logic                gone;
    int                  hit;
    int                  spare;
    op    = req[1:0];
    key   = req[2 +: KEY_BITS];
    s     = req[23:18];
    gone  = req[24];
    r     = '0;
    hit   = -1;
    spare = -1;
    case (op)
      OP_GET: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (hit < 0 && slot_refs[i] != 0 && slot_key[i] == key) hit = i;
          if (spare < 0 && slot_refs[i] == 0) spare = i;
        end
        if (hit >= 0) begin
          r.slot_index = hit[5:0];
          if (slot_refs[hit] == REFS_MAX) begin
            r.status = ST_ERROR;     // count saturated, left alone
          end else begin
            slot_refs[hit] = slot_refs[hit] + 1'b1;
            r.status = ST_HIT;
          end
        end else if (spare >= 0) begin
          slot_key[spare]  = key;
          slot_refs[spare] = REFS_BITS'(1);
          r.slot_index     = spare[5:0];
          r.status         = ST_LOAD;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_PUT: begin
        r.slot_index = s;
        if (int'(s) >= TABLE_SLOTS || slot_refs[s] == 0) begin
          r.status = ST_ERROR;
        end else if (slot_refs[s] == 1) begin
          r.released_key = 16'(slot_key[s]);
          r.status       = gone ? ST_WB_FREE : ST_WRITEBACK;
          slot_refs[s]   = '0;
          slot_key[s]    = '0;
        end else begin
          slot_refs[s] = slot_refs[s] - 1'b1;
          r.status     = ST_DROPPED;
        end
      end
      OP_CLEAR: begin
        empty_table();
        r.status = ST_CLEARED;
      end
      default: begin
        r.status = ST_ERROR;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      empty_table();
      awaited_resps.delete();
      outstanding <= 0;
    end else begin
      // a response at this edge always belongs to an earlier request
      if (m_tvalid && m_tready) begin
        if (awaited_resps.size() == 0) begin
          note_mismatch("response with no request pending", m_tdata, '0);
        end else begin
          want = awaited_resps.pop_front();
          if (m_tdata[5:0] != want.slot_index)
            note_mismatch("slot_index", 32'(m_tdata[5:0]), 32'(want.slot_index));
          if (m_tdata[8:6] != want.status)
            note_mismatch("status", 32'(m_tdata[8:6]), 32'(want.status));
          if (m_tdata[24:9] != want.released_key)
            note_mismatch("released_key", 32'(m_tdata[24:9]), 32'(want.released_key));
        end
      end
      if (s_tvalid && s_tready) awaited_resps.push_back(serve_request(s_tdata));
      outstanding <= awaited_resps.size();
    end
    fail_count <= mismatches;
  end

endmodule

// File: bench/tb_refcounted_inode_slot_table_top.sv
module tb_refcounted_inode_slot_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rcst_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 250;
  localparam int         QUIET_LIMIT = 3000;
  localparam int         ITEM_TARGET = 1100;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  int          fail_count;
  int          outstanding;
  int          issued;
  int          quiet = 0;
  bit          gaps_on;
  bit          hold_off_req;
  bit          hold_off_done;
  logic [15:0] key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  refcounted_inode_slot_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  slot_table_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic [1:0] op, input logic [15:0] key,
                          input logic [5:0] slot, input logic gone);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tdata  = {7'd0, gone, slot, key, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    issued++;
  endtask

  task automatic get_req(input logic [15:0] key);
    send_req(OP_GET, key, 6'($urandom), 1'($urandom));
  endtask

  task automatic put_req(input logic [5:0] slot, input logic gone);
    send_req(OP_PUT, 16'($urandom), slot, gone);
  endtask

  task automatic clear_req();
    send_req(OP_CLEAR, 16'($urandom), 6'($urandom), 1'($urandom));
  endtask

  // Small key pool and low slots keep gets hitting and puts landing on live slots.
  task automatic mix_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      get_req(key_pool[$urandom_range(0, 7)]);
    else if (pick < 90) put_req(6'($urandom_range(0, 9)), 1'($urandom));
    else if (pick < 97) get_req(16'($urandom));
    else if (pick < 99) put_req(6'($urandom), 1'($urandom));
    else                clear_req();
  endtask

  // receiver side
  initial begin
    m_tready      = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_refcounted_inode_slot_table_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [15:0] base;
    int          episode;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    gaps_on      = 1'b0;
    hold_off_req = 1'b0;
    issued       = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed
    get_req(16'h0000);
    get_req(16'hFFFF);
    get_req(16'h0000);
    put_req(6'd0, 1'b0);
    put_req(6'd0, 1'b1);
    put_req(6'd0, 1'b0);    // unused slot
    put_req(6'd63, 1'b1);   // top slot, unused
    get_req(16'hFFFF);
    put_req(6'd1, 1'b0);
    put_req(6'd1, 1'b0);
    send_req(OP_UNUSED, 16'hFFFF, 6'd63, 1'b1);
    send_req(OP_CLEAR, 16'h5A5A, 6'h2A, 1'b1);
    get_req(16'h8001);
    get_req(16'h7FFE);
    put_req(6'd0, 1'b0);
    get_req(16'h1357);      // reuses the lowest freed slot
    get_req(16'h7FFE);
    send_req(OP_UNUSED, 16'h0000, 6'd0, 1'b0);
    put_req(6'd1, 1'b1);
    clear_req();

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = 16'($urandom);
    gaps_on = 1'b1;

    // drive one key to count saturation
    clear_req();
    base = 16'($urandom);
    repeat (257) get_req(base);
    put_req(6'd0, 1'($urandom));
    get_req(base);
    get_req(base);

    episode = 0;
    while (issued < ITEM_TARGET - 150) begin
      episode++;
      if (episode == 3) hold_off_req = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          // fill every slot, then one more distinct key
          clear_req();
          base = 16'($urandom);
          for (int i = 0; i <= TABLE_SLOTS; i++) get_req(base + 16'(i));
          repeat (10) mix_req();
        end
        1: begin
          repeat (10) send_req(2'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
        end
        default: begin
          repeat (30) mix_req();
        end
      endcase
      if (hold_off_req) wait (hold_off_done);
    end

    gaps_on = 1'b0;
    while (issued < ITEM_TARGET) mix_req();

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_refcounted_inode_slot_table_top: PASS");
    end else begin
      $display("tb_refcounted_inode_slot_table_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rcst_pkg.sv
hdl/rcst_cell.sv
hdl/refcounted_inode_slot_table_top.sv
bench/slot_table_checker.sv
bench/tb_refcounted_inode_slot_table_top.sv
